// ----- rtl/idq_pkg.sv -----
// ----------------------------------------------------------------------------
// idq_pkg - shared constants and types for the indexed ordered deque
// Sizes, operation and status codes, and the control word broadcast to the
// row of storage cells.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels
  localparam int OP_W   = 4;
  localparam int POS_W  = 5;
  localparam int ELEM_W = 32;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 4;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 4'd5;
  localparam logic [OP_W-1:0] OP_SEARCH     = 4'd6;
  localparam logic [OP_W-1:0] OP_DUMP_FWD   = 4'd7;
  localparam logic [OP_W-1:0] OP_DUMP_BWD   = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef logic [WORD_WIDTH-1:0] word_t;

  // What every cell does in a cycle
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INS,
    CM_REM,
    CM_ROTF,
    CM_ROTB,
    CM_SRCH
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] occ;
    word_t            key;
  } cell_ctrl_t;

endpackage

// ----- rtl/idq_if.sv -----
// ----------------------------------------------------------------------------
// idq_if - request and result channels of the indexed ordered deque
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface idq_in_if import idq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;

  modport source (output valid, opcode, position, element, input ready);
  modport sink   (input valid, opcode, position, element, output ready);
endinterface

interface idq_out_if import idq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] found_index;
  logic [DATA_W-1:0] data_out;
  logic [LEN_W-1:0]  length;
  logic              last;

  modport source (output valid, status, found_index, data_out, length, last, input ready);
  modport sink   (input valid, status, found_index, data_out, length, last, output ready);
endinterface

// ----- rtl/idq_cell.sv -----
// ----------------------------------------------------------------------------
// idq_cell - one storage cell of the deque row
// Holds one word; loads, takes a neighbour's word or holds as the broadcast
// control and its own position dictate. Registers a search match.
// ----------------------------------------------------------------------------
module idq_cell import idq_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  word_t            left_word,
  input  word_t            right_word,
  input  word_t            wrap_word,
  output word_t            word,
  output logic             match
);

  word_t            word_r;
  word_t            word_nxt;
  logic             match_r;
  logic [CNT_W-1:0] me;

  assign me    = CNT_W'(idx);
  assign word  = word_r;
  assign match = match_r;

  always_comb begin
    word_nxt = word_r;
    case (ctrl.mode)
      CM_INS: begin
        if (me > ctrl.pos) begin
          word_nxt = left_word;
        end else if (me == ctrl.pos) begin
          word_nxt = ctrl.key;
        end
      end
      CM_REM: begin
        if (me >= ctrl.pos) begin
          word_nxt = right_word;
        end
      end
      CM_ROTF: begin
        if ((me + 1'b1) == ctrl.occ) begin
          word_nxt = wrap_word;
        end else if (me < ctrl.occ) begin
          word_nxt = right_word;
        end
      end
      CM_ROTB: begin
        if (me == '0) begin
          word_nxt = wrap_word;
        end else if (me < ctrl.occ) begin
          word_nxt = left_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (ctrl.mode == CM_SRCH) begin
      match_r <= (word_r == ctrl.key) && (me < ctrl.occ);
    end
  end

endmodule

// ----- rtl/idq_chain.sv -----
// ----------------------------------------------------------------------------
// idq_chain - row of deque cells
// Wires each cell to its neighbours, selects the front and back words and
// encodes the first registered search match.
// ----------------------------------------------------------------------------
module idq_chain import idq_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  output word_t            front_word,
  output word_t            tail_word,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx
);

  word_t            words   [CAPACITY];
  word_t            left_w  [CAPACITY];
  word_t            right_w [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CNT_W-1:0] tail_pos;
  word_t            wrap_word;

  assign tail_pos   = ctrl.occ - 1'b1;
  assign tail_word  = words[tail_pos[IDX_W-1:0]];
  assign front_word = words[0];
  // Forward rotation feeds the front word to the back; backward the reverse
  assign wrap_word  = (ctrl.mode == CM_ROTB) ? tail_word : words[0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_lo
      assign left_w[g] = '0;
    end else begin : g_lo
      assign left_w[g] = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right_w[g] = '0;
    end else begin : g_hi
      assign right_w[g] = words[g+1];
    end

    idq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .left_word  (left_w[g]),
      .right_word (right_w[g]),
      .wrap_word  (wrap_word),
      .word       (words[g]),
      .match      (match[g])
    );
  end

  always_comb begin
    hit     = |match;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

endmodule

// ----- rtl/indexed_ordered_deque_top.sv -----
// ----------------------------------------------------------------------------
// indexed_ordered_deque_top - bounded ordered list with indexed access
// A list of up to CAPACITY words held in a row of cells, position 0 at the
// front. Push, pop-front, insert and remove shift the cells; pop-back only
// shrinks the count. These operations sustain one request per cycle while
// the result channel drains; their single result appears the cycle after the
// transfer. In a search the cells compare and register their match bits,
// then the first match is encoded into the result. In a dump the row
// rotates one place per result, emitting the front word (forward) or the
// back word (backward), and is back in order after the last. A full list
// flags status list-full and leaves the contents alone.
// Results wait in an output register; while it holds a result that is not
// yet taken, no new request is accepted.
// ----------------------------------------------------------------------------
module indexed_ordered_deque_top import idq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  idq_in_if.sink    in_if,
  idq_out_if.source out_if
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              bwd_r, bwd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [FIDX_W-1:0] out_fidx_r, out_fidx_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              in_fire;
  logic              out_load;
  logic              full;
  logic              dump_last;
  cell_ctrl_t        ctrl;
  word_t             front_word;
  word_t             tail_word;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  dump_pos;

  // The output register is free when empty or being taken this cycle
  assign out_free     = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_if.valid && in_if.ready;
  assign full         = (occ_r == CNT_W'(CAPACITY));
  assign dump_last    = ((CNT_W'(cnt_r) + 1'b1) == occ_r);
  assign dump_pos     = bwd_r ? IDX_W'(occ_r - 1'b1 - CNT_W'(cnt_r)) : cnt_r;

  idq_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .front_word (front_word),
    .tail_word  (tail_word),
    .hit        (hit),
    .hit_idx    (hit_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    cnt_nxt        = cnt_r;
    bwd_nxt        = bwd_r;
    ctrl.mode      = CM_HOLD;
    ctrl.pos       = '0;
    ctrl.occ       = occ_r;
    ctrl.key       = WORD_WIDTH'(in_if.element);
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_fidx_nxt   = '0;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (in_if.opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.pos  = '0;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.pos  = occ_r;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_INSERT_AT: begin
              // Range check takes precedence over the full check
              if (in_if.position > occ_r) begin
                out_status_nxt = ST_RANGE;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.pos  = CNT_W'(in_if.position);
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ctrl.mode = CM_REM;
                ctrl.pos  = '0;
                occ_nxt   = occ_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              // Dropping the back word needs no shift: just shrink the count
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                occ_nxt = occ_r - 1'b1;
              end
            end
            OP_REMOVE_AT: begin
              if (in_if.position >= occ_r) begin
                out_status_nxt = ST_RANGE;
              end else begin
                ctrl.mode = CM_REM;
                ctrl.pos  = CNT_W'(in_if.position);
                occ_nxt   = occ_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              // Capture match bits now, report from the search state once the output is free
              out_load  = 1'b0;
              ctrl.mode = CM_SRCH;
              state_nxt = S_SRCH;
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_load  = 1'b0;
                state_nxt = S_DUMP;
                cnt_nxt   = '0;
                bwd_nxt   = (in_if.opcode == OP_DUMP_BWD);
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = hit ? ST_OK : ST_NOTFOUND;
          out_fidx_nxt   = hit ? FIDX_W'(hit_idx) : '0;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        // Emit one element per transfer and rotate the row one place
        if (out_free) begin
          out_load     = 1'b1;
          ctrl.mode    = bwd_r ? CM_ROTB : CM_ROTF;
          out_fidx_nxt = FIDX_W'(dump_pos);
          out_data_nxt = DATA_W'(bwd_r ? tail_word : front_word);
          out_last_nxt = dump_last;
          cnt_nxt      = cnt_r + 1'b1;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_len_nxt = LEN_W'(occ_nxt);

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload unless a new result is loaded
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_fidx_r   <= out_fidx_nxt;
      out_data_r   <= out_data_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.found_index = out_fidx_r;
  assign out_if.data_out    = out_data_r;
  assign out_if.length      = out_len_r;
  assign out_if.last        = out_last_r;

`ifndef NO_ASSERTIONS
  // Count never passes the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // Count moves only on a request transfer
  a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(occ_r))
    else $error("occupancy changed without a request");

  // The final dump result returns the sequencer to idle
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && out_free && dump_last) |=> (state_r == S_IDLE && out_if.last))
    else $error("dump did not end on its last element");
`endif

endmodule
